// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: ante implies cons");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: ante implies cons on the next cycle");

`endif

// ----- rtl/qat_pkg.sv -----
// ----------------------------------------------------------------------------
// qat_pkg
// Types and character constants shared by the argument tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qat_pkg;

	// Character codes the scanner reacts to.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DQUOTE = 8'h22;
	localparam logic [7:0] CHAR_SQUOTE = 8'h27;
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;

	// Scan mode of the line.
	typedef enum logic [1:0] {
		MODE_BETWEEN = 2'd0,
		MODE_PLAIN   = 2'd1,
		MODE_QUOTED  = 2'd2
	} mode_t;

	// Scanner state carried from one byte to the next.
	typedef struct packed {
		mode_t      mode;
		logic       quote_single;
		logic       odd_bslash;
		logic [7:0] args;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		mode: MODE_BETWEEN, quote_single: 1'b0, odd_bslash: 1'b0, args: 8'd0
	};

	// Classification of one byte.
	typedef struct packed {
		logic       done;
		logic [7:0] count;
		logic       closes;
		logic       opens;
		logic       keep;
		logic [7:0] data;
	} scan_res_t;

	// Space, tab, CR and LF separate plain arguments.
	function automatic logic is_blank(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/qat_step.sv -----
// ----------------------------------------------------------------------------
// qat_step
// Per-byte classifier: marks text, argument starts and ends, and computes the
// scanner state that follows the byte.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_step #(
	parameter int MAX_ARGS = 255
) (
	input  logic [7:0]          in_byte,
	input  logic                line_end,
	input  qat_pkg::scan_state_t cur,
	output qat_pkg::scan_state_t nxt,
	output qat_pkg::scan_res_t   res
);
	import qat_pkg::*;

	localparam logic [7:0] MaxArgs = 8'(MAX_ARGS);

	logic        keep;
	logic        opens;
	logic        closes;
	logic        done;
	logic        count_it;
	logic [7:0]  quote_char;
	logic [7:0]  args_new;
	scan_state_t work;

	// Mode transitions for one byte.
	always_comb begin
		keep       = 1'b0;
		opens      = 1'b0;
		closes     = 1'b0;
		done       = 1'b0;
		count_it   = 1'b0;
		work       = cur;
		quote_char = cur.quote_single ? CHAR_SQUOTE : CHAR_DQUOTE;
		if (in_byte == CHAR_NUL) begin
			closes    = (cur.mode == MODE_PLAIN) || (cur.mode == MODE_QUOTED);
			work.mode = MODE_BETWEEN;
			done      = 1'b1;
		end else begin
			unique case (cur.mode)
				MODE_PLAIN: begin
					if (is_blank(in_byte)) begin
						closes    = 1'b1;
						work.mode = MODE_BETWEEN;
					end else begin
						keep = 1'b1;
					end
				end
				MODE_QUOTED: begin
					if ((in_byte == quote_char) && !cur.odd_bslash) begin
						closes    = 1'b1;
						work.mode = MODE_BETWEEN;
					end else begin
						keep            = 1'b1;
						work.odd_bslash = (in_byte == CHAR_BSLASH) ? !cur.odd_bslash : 1'b0;
					end
				end
				default: begin
					// Between arguments; the unused mode code behaves the same.
					if ((in_byte == CHAR_DQUOTE) || (in_byte == CHAR_SQUOTE)) begin
						opens             = 1'b1;
						count_it          = 1'b1;
						work.mode         = MODE_QUOTED;
						work.quote_single = (in_byte == CHAR_SQUOTE);
						work.odd_bslash   = 1'b0;
					end else if (!is_blank(in_byte)) begin
						opens     = 1'b1;
						keep      = 1'b1;
						count_it  = 1'b1;
						work.mode = MODE_PLAIN;
					end else begin
						work.mode = MODE_BETWEEN;
					end
				end
			endcase
			if (line_end) begin
				if (work.mode != MODE_BETWEEN) begin
					closes = 1'b1;
				end
				work.mode = MODE_BETWEEN;
				done      = 1'b1;
			end
		end
	end

	// Saturating argument count.
	assign args_new = (count_it && (cur.args < MaxArgs)) ? cur.args + 8'd1 : cur.args;

	// The state returns to reset at the end of a line.
	always_comb begin
		nxt      = work;
		nxt.args = args_new;
		if (done) begin
			nxt = SCAN_RESET;
		end
	end

	assign res = '{
		done: done, count: args_new, closes: closes, opens: opens, keep: keep,
		data: in_byte
	};

endmodule

`default_nettype wire

// ----- rtl/quoted_argument_tokenizer.sv -----
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a command line, one byte per word, into shell-style arguments.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one byte of the command line per word, with tlast
//   marking the final byte of a line (a zero byte also ends the line). The
//   master channel returns one word for every byte: the byte itself, whether
//   it is argument text, whether an argument opens or closes at it, and the
//   number of arguments begun so far; tlast flags the word that ends the line,
//   where the count is final.
//   A byte is registered on entry and classified on its way into the output
//   register. One word per cycle is sustained while the receiver takes every
//   word; the only loop is the update of the scan state register between
//   consecutive bytes.
//   Reset clears both stages and puts the scanner between arguments with a
//   count of zero; the scanner also returns to that state after every line.
//   When the receiver stalls, the output word holds, the input stage fills,
//   and s_tready drops until the output word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_argument_tokenizer #(
	parameter int MAX_ARGS = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	input  logic        s_tlast,  // line_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] out_byte, [8] keep, [9] opens_arg,
	                              // [10] closes_arg, [18:11] arg_count, rest zero
	output logic        m_tlast   // line_done
);
	import qat_pkg::*;

	`include "assert_macros.svh"

	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic        in_last_s1;
	logic        out_valid_q;
	scan_res_t   out_q;
	scan_state_t state_q;
	scan_state_t state_nxt;
	scan_res_t   step_res;
	logic        advance;

	// A byte moves on when the output register is free or being emptied.
	assign advance  = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
			in_last_s1 <= s_tlast;
		end
	end

	// Byte classification against the current scan state.
	qat_step #(
		.MAX_ARGS(MAX_ARGS)
	) u_step (
		.in_byte (in_byte_s1),
		.line_end(in_last_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (step_res)
	);

	// Scan state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SCAN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.count, out_q.closes, out_q.opens, out_q.keep, out_q.data};
	assign m_tlast  = out_q.done;

	// Text always belongs to an argument that has been counted.
	`ASSERT_IMP(a_keep_counted, clk, arst_n, m_tvalid && m_tdata[8], m_tdata[18:11] != 8'd0)
	// A zero byte always ends the line.
	`ASSERT_IMP(a_nul_ends_line, clk, arst_n, m_tvalid && (m_tdata[7:0] == 8'd0), m_tlast)
	// The scanner is back in its reset state after a line ends.
	`ASSERT_NXT(a_line_reset, clk, arst_n, advance && step_res.done,
		(state_q.mode == MODE_BETWEEN) && (state_q.args == 8'd0))

endmodule

`default_nettype wire
